@@ design/pat_pkg.sv @@
`default_nettype none

package pat_pkg;

	localparam int PERIOD_WIDTH = 16;
	localparam int FIELD_W = 16;
	localparam int TOTAL_W = PERIOD_WIDTH + 1;
	localparam int TALLY_W = 16;
	localparam int OUT_W = 16;
	localparam int DIV_W = (TOTAL_W > FIELD_W) ? TOTAL_W : FIELD_W;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W = 2;

	localparam int PW_IN = (PERIOD_WIDTH < FIELD_W) ? PERIOD_WIDTH : FIELD_W;
	localparam logic [FIELD_W-1:0] PERIOD_MASK = FIELD_W'((64'd1 << PW_IN) - 64'd1);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	localparam logic [FIELD_W-1:0] THRESHOLD_RESET = 16'd50000;
	localparam logic [FIELD_W-1:0] NUMERATOR_RESET = 16'd40000;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR = 2'd1;

	localparam logic REQ_CAPTURE = 1'b0;
	localparam logic REQ_OVERFLOW = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [FIELD_W-1:0] capture_period;
	} req_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] average_period;
		logic [OUT_W-1:0] speed_value;
	} rsp_item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [TALLY_W-1:0] tally;
	} job_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctrl_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_AVG,
		BK_SPD,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic pop;
		logic start_avg;
		logic zero_rsp;
		logic start_spd;
		logic skip_spd;
		logic fin_spd;
		logic load_rsp;
	} back_ctrl_t;

endpackage

`default_nettype wire

@@ design/pat_front.sv @@
`default_nettype none

module pat_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire pat_pkg::req_item_t            req,
	input  wire logic [pat_pkg::FIELD_W-1:0]   threshold,
	input  wire pat_pkg::queue_stat_t          q_stat,
	output logic                               q_push,
	output pat_pkg::job_t                      q_job
);
	import pat_pkg::*;

	localparam int CMP_W = (TOTAL_W > FIELD_W) ? TOTAL_W : FIELD_W;

	logic [TOTAL_W-1:0] total_q;
	logic [TALLY_W-1:0] tally_q;
	logic [TOTAL_W-1:0] period;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total_nx;
	logic [TALLY_W-1:0] tally_nx;
	logic               accept;
	logic               overflow;
	logic               report;

	assign req_stall = q_stat.full;
	assign accept = req_valid && !req_stall;
	assign overflow = (req.req_type == REQ_OVERFLOW);

	always_comb begin
		period = TOTAL_W'(req.capture_period & PERIOD_MASK);
		sum = {1'b0, total_q} + {1'b0, period};
		total_nx = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
		tally_nx = (tally_q == TALLY_MAX) ? tally_q : tally_q + 1'b1;
		report = overflow || (CMP_W'(total_nx) > CMP_W'(threshold));
	end

	assign q_push = accept && report;
	assign q_job.total = overflow ? total_q : total_nx;
	assign q_job.tally = overflow ? tally_q : tally_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			tally_q <= '0;
		end else if (accept) begin
			if (report) begin
				total_q <= '0;
				tally_q <= '0;
			end else begin
				total_q <= total_nx;
				tally_q <= tally_nx;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/pat_queue.sv @@
`default_nettype none

module pat_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pat_pkg::queue_ctrl_t ctrl,
	input  wire pat_pkg::job_t        wr_job,
	output pat_pkg::queue_stat_t      stat,
	output pat_pkg::job_t             rd_job
);
	import pat_pkg::*;

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.valid = (count_q != '0);
	assign stat.full = (count_q == QCNT_W'(QDEPTH));
	assign do_push = ctrl.push && !stat.full;
	assign do_pop = ctrl.pop && stat.valid;
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/pat_back.sv @@
`default_nettype none

module pat_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pat_pkg::queue_stat_t        q_stat,
	input  wire pat_pkg::job_t               q_job,
	output logic                             q_pop,
	input  wire logic [pat_pkg::FIELD_W-1:0] numerator,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output pat_pkg::rsp_item_t               rsp
);
	import pat_pkg::*;

	back_state_t          state_q;
	back_state_t          state_d;
	back_ctrl_t           ctl;
	logic [DIV_W:0]       rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [OUT_W-1:0]     avg_q;
	logic [OUT_W-1:0]     spd_q;
	logic [DIV_W:0]       shifted;
	logic                 fits;
	logic [DIV_W:0]       rem_nx;
	logic [DIV_W-1:0]     quo_nx;
	logic [OUT_W-1:0]     avg_nx;
	logic                 last;
	logic                 rsp_free;
	logic                 tally_zero;

	always_comb begin
		shifted = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
		fits = (shifted >= {1'b0, dvs_q});
		rem_nx = fits ? shifted - {1'b0, dvs_q} : shifted;
		quo_nx = {quo_q[DIV_W-2:0], fits};
		avg_nx = (quo_nx > DIV_W'(OUT_MAX)) ? OUT_MAX : quo_nx[OUT_W-1:0];
		last = (cnt_q == DIV_CNT_W'(DIV_W - 1));
	end

	assign rsp_free = !rsp_valid || !rsp_stall;
	assign tally_zero = (q_job.tally == '0);
	assign q_pop = ctl.pop;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_stat.valid) begin
					state_d = tally_zero ? BK_DONE : BK_AVG;
				end
			end
			BK_AVG: begin
				if (last) begin
					state_d = (avg_nx == '0) ? BK_DONE : BK_SPD;
				end
			end
			BK_SPD: begin
				if (last) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (rsp_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			BK_IDLE: begin
				ctl.pop = q_stat.valid;
				ctl.start_avg = q_stat.valid && !tally_zero;
				ctl.zero_rsp = q_stat.valid && tally_zero;
			end
			BK_AVG: begin
				ctl.start_spd = last && (avg_nx != '0);
				ctl.skip_spd = last && (avg_nx == '0);
			end
			BK_SPD: begin
				ctl.fin_spd = last;
			end
			BK_DONE: begin
				ctl.load_rsp = rsp_free;
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_rsp) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start_avg) begin
			rem_q <= '0;
			quo_q <= DIV_W'(q_job.total);
			dvs_q <= DIV_W'(q_job.tally);
			cnt_q <= '0;
		end else if (ctl.start_spd) begin
			rem_q <= '0;
			quo_q <= DIV_W'(numerator);
			dvs_q <= DIV_W'(avg_nx);
			cnt_q <= '0;
		end else if (state_q == BK_AVG || state_q == BK_SPD) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			cnt_q <= cnt_q + 1'b1;
		end
		if (ctl.zero_rsp) begin
			avg_q <= '0;
			spd_q <= '0;
		end
		if (ctl.start_spd || ctl.skip_spd) begin
			avg_q <= avg_nx;
		end
		if (ctl.skip_spd) begin
			spd_q <= '0;
		end
		if (ctl.fin_spd) begin
			spd_q <= quo_nx[OUT_W-1:0];
		end
		if (ctl.load_rsp) begin
			rsp.average_period <= avg_q;
			rsp.speed_value <= spd_q;
		end
	end

endmodule

`default_nettype wire

@@ design/period_average_tachometer.sv @@
// A report becomes a queued job; the back end divides it and registers the result.
// Captures that cause no report are taken one per cycle while the job queue has room.
// Reports are carried out one at a time by a single shared restoring divider, one
// quotient bit per cycle; further reports wait in the job queue until it is free.
// Reset clears the period total, the tally, the job queue and the result valid flag,
// and loads the threshold and numerator registers with 50000 and 40000.
`default_nettype none

module period_average_tachometer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire pat_pkg::req_item_t            req,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output pat_pkg::rsp_item_t                 rsp,
	input  wire logic                          cfg_we,
	input  wire logic [pat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pat_pkg::FIELD_W-1:0]   cfg_data
);
	import pat_pkg::*;

	logic [FIELD_W-1:0] threshold_q;
	logic [FIELD_W-1:0] numerator_q;
	queue_ctrl_t        q_ctrl;
	queue_stat_t        q_stat;
	job_t               wr_job;
	job_t               rd_job;
	logic               q_push;
	logic               q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			numerator_q <= NUMERATOR_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_THRESHOLD) begin
				threshold_q <= cfg_data;
			end
			if (cfg_index == REG_NUMERATOR) begin
				numerator_q <= cfg_data;
			end
		end
	end

	assign q_ctrl.push = q_push;
	assign q_ctrl.pop = q_pop;

	pat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.threshold (threshold_q),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_job     (wr_job)
	);

	pat_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.wr_job (wr_job),
		.stat   (q_stat),
		.rd_job (rd_job)
	);

	pat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_job     (rd_job),
		.q_pop     (q_pop),
		.numerator (numerator_q),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

@@ design/pat_checker.sv @@
`default_nettype none

module pat_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_stall,
	input wire pat_pkg::req_item_t            req,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_stall,
	input wire pat_pkg::rsp_item_t            rsp,
	input wire logic                          cfg_we,
	input wire logic [pat_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [pat_pkg::FIELD_W-1:0]   cfg_data
);
	import pat_pkg::*;

	logic unused;
	assign unused = req_valid ^ (^req) ^ cfg_we ^ (^cfg_index) ^ (^cfg_data);

	// A stalled result beat stays up and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// A zero average never comes with a nonzero speed.
	a_zero_avg: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.average_period != '0 || rsp.speed_value == '0))
		else $error("nonzero speed reported with zero average");

	// During reset no result is offered and requests are not held off.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid && !req_stall)
		else $error("handshake active during reset");

endmodule

bind period_average_tachometer pat_checker u_pat_checker (.*);

`default_nettype wire

@@ tb/tach_checker.sv @@
`timescale 1ns / 100ps

module tach_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	input  wire logic                          req_stall,
	input  wire pat_pkg::req_item_t            req,
	input  wire logic                          rsp_valid,
	input  wire logic                          rsp_stall,
	input  wire pat_pkg::rsp_item_t            rsp,
	input  wire logic                          cfg_we,
	input  wire logic [pat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pat_pkg::FIELD_W-1:0]   cfg_data,
	output int                                 fails,
	output int                                 outstanding
);
	import pat_pkg::*;

	logic [TOTAL_W-1:0] acc_ticks;
	logic [TALLY_W-1:0] acc_count;
	logic [FIELD_W-1:0] thr_reg;
	logic [FIELD_W-1:0] num_reg;
	rsp_item_t          expected_reports[$];
	rsp_item_t          predicted;
	rsp_item_t          wanted;
	int                 err_count;
	int                 pending_n;

	assign fails = err_count;
	assign outstanding = pending_n;

	function automatic rsp_item_t close_window();
		rsp_item_t          r;
		logic [TOTAL_W-1:0] mean;
		mean = '0;
		if (acc_count != '0) begin
			mean = acc_ticks / TOTAL_W'(acc_count);
		end
		if (mean > TOTAL_W'(OUT_MAX)) begin
			mean = TOTAL_W'(OUT_MAX);
		end
		r.average_period = mean[OUT_W-1:0];
		r.speed_value = '0;
		if (r.average_period != '0) begin
			r.speed_value = OUT_W'(num_reg / r.average_period);
		end
		acc_ticks = '0;
		acc_count = '0;
		return r;
	endfunction

	function automatic bit tach_step(input req_item_t it, output rsp_item_t r);
		logic [TOTAL_W:0]   sum;
		logic [FIELD_W-1:0] ticks;
		r = '0;
		if (it.req_type == REQ_OVERFLOW) begin
			r = close_window();
			return 1'b1;
		end
		ticks = it.capture_period & PERIOD_MASK;
		sum = {1'b0, acc_ticks} + (TOTAL_W + 1)'(ticks);
		acc_ticks = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
		if (acc_count < TALLY_MAX) begin
			acc_count = acc_count + 1'b1;
		end
		if (acc_ticks > TOTAL_W'(thr_reg)) begin
			r = close_window();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_ticks = '0;
			acc_count = '0;
			thr_reg = THRESHOLD_RESET;
			num_reg = NUMERATOR_RESET;
			expected_reports.delete();
			err_count = 0;
			pending_n <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD: thr_reg = cfg_data;
					REG_NUMERATOR: num_reg = cfg_data;
					default: ;
				endcase
			end
			if (req_valid && !req_stall) begin
				if (tach_step(req, predicted)) begin
					expected_reports.push_back(predicted);
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_reports.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result beat, expected none, got avg %0d speed %0d",
						$time, rsp.average_period, rsp.speed_value);
				end else begin
					wanted = expected_reports.pop_front();
					if (rsp.average_period !== wanted.average_period) begin
						err_count++;
						$display("%0t: average_period expected %0d got %0d",
							$time, wanted.average_period, rsp.average_period);
					end
					if (rsp.speed_value !== wanted.speed_value) begin
						err_count++;
						$display("%0t: speed_value expected %0d got %0d",
							$time, wanted.speed_value, rsp.speed_value);
					end
				end
			end
			pending_n <= expected_reports.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import pat_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 50;
	localparam int LONG_HOLD = 400;
	localparam int PHASE_ITEMS = 130;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_item_t            req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_item_t            rsp;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FIELD_W-1:0]   cfg_data;
	int                   fails;
	int                   outstanding;

	int                   send_idle_pct;
	int                   recv_stall_pct;
	bit                   long_hold;
	logic [FIELD_W-1:0]   cur_thr;
	int                   cycles;

	period_average_tachometer dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tach_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fails(fails),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("period_average_tachometer test failed");
				$finish;
			end
		end
	end

	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic offer_event(input logic kind, input logic [FIELD_W-1:0] ticks);
		req_item_t it;
		it.req_type = kind;
		it.capture_period = ticks;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_THRESHOLD) begin
			cur_thr = val;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [FIELD_W-1:0] pick_period();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return FIELD_W'($urandom);
			default: return FIELD_W'($urandom_range(0, int'(cur_thr) / 3 + 1));
		endcase
	endfunction

	int phase_send[8] = '{0, 80, 0, 11, 0, 80, 0, 11};
	int phase_recv[8] = '{0, 0, 80, 11, 0, 0, 80, 11};

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		long_hold = 1'b0;
		cur_thr = THRESHOLD_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_event(REQ_OVERFLOW, 16'd0);
		offer_event(REQ_CAPTURE, 16'd0);
		offer_event(REQ_OVERFLOW, 16'hFFFF);
		offer_event(REQ_CAPTURE, 16'hFFFF);
		offer_event(REQ_CAPTURE, 16'd50000);
		offer_event(REQ_CAPTURE, 16'd0);
		offer_event(REQ_OVERFLOW, 16'h5555);
		offer_event(REQ_CAPTURE, 16'd50001);
		offer_event(REQ_CAPTURE, 16'd1);
		offer_event(REQ_CAPTURE, 16'd1);
		offer_event(REQ_CAPTURE, 16'd3);
		offer_event(REQ_OVERFLOW, 16'hAAAA);
		settle();
		write_reg(REG_THRESHOLD, 16'd0);
		write_reg(REG_NUMERATOR, 16'hFFFF);
		offer_event(REQ_CAPTURE, 16'd0);
		offer_event(REQ_CAPTURE, 16'd1);
		offer_event(REQ_CAPTURE, 16'd7);
		settle();
		write_reg(REG_THRESHOLD, 16'hFFFF);
		offer_event(REQ_CAPTURE, 16'hFFFF);
		offer_event(REQ_CAPTURE, 16'hFFFF);
		offer_event(REQ_CAPTURE, 16'd2);
		offer_event(REQ_OVERFLOW, 16'd0);
		settle();

		for (int p = 0; p < 8; p++) begin
			case (p)
				1: write_reg(REG_THRESHOLD, 16'd0);
				3: write_reg(REG_THRESHOLD, 16'hFFFF);
				5: write_reg(REG_THRESHOLD, FIELD_W'($urandom_range(0, 2000)));
				default: write_reg(REG_THRESHOLD, FIELD_W'($urandom));
			endcase
			case (p)
				2: write_reg(REG_NUMERATOR, 16'd0);
				4: write_reg(REG_NUMERATOR, 16'hFFFF);
				6: write_reg(REG_NUMERATOR, 16'd1);
				default: write_reg(REG_NUMERATOR, FIELD_W'($urandom));
			endcase
			send_idle_pct = phase_send[p];
			recv_stall_pct = phase_recv[p];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 0 && i == 40) begin
					long_hold = 1'b1;
				end
				if (i == PHASE_ITEMS / 2 && $urandom_range(1) == 1) begin
					settle();
				end
				if ($urandom_range(7) == 0) begin
					offer_event(REQ_OVERFLOW, FIELD_W'($urandom));
				end else begin
					offer_event(REQ_CAPTURE, pick_period());
				end
			end
			settle();
		end

		// A burst of overflows against a receiver that holds off fills the block.
		send_idle_pct = 0;
		long_hold = 1'b1;
		for (int i = 0; i < 16; i++) begin
			offer_event(REQ_OVERFLOW, FIELD_W'($urandom));
		end
		settle();

		if (fails == 0) begin
			$display("period_average_tachometer test passed");
		end else begin
			$display("period_average_tachometer test failed");
		end
		$finish;
	end

endmodule
